// File: sv/crsc_pkg.sv
// Package: shared types and constants of the climate relay safety controller.
`timescale 1ns / 1ps

package crsc_pkg;

  localparam int TimerBits         = 32;
  localparam int MsPerMinute       = 60000;
  localparam int LimitMinutesBits  = 16;
  localparam int LimitMsBits       = 32;
  localparam int CmpBits           = (TimerBits > LimitMsBits) ? TimerBits : LimitMsBits;
  localparam int LimitMinutesReset = 30;
  localparam int HourBits          = 5;
  localparam int DayStartReset     = 6;
  localparam int NightStartReset   = 22;
  localparam int NumRelays         = 4;
  localparam int CfgIndexBits      = 3;
  localparam int CfgDataBits       = 16;
  localparam int ActionBits        = 3;

  localparam logic [LimitMsBits-1:0] LimitMsReset =
    LimitMsBits'(LimitMinutesReset * MsPerMinute);

  // Pin positions in the active-low pin word.
  localparam int PinHeater  = 0;
  localparam int PinCooling = 1;
  localparam int PinDehumid = 2;
  localparam int PinSpare   = 3;

  typedef enum logic [ActionBits-1:0] {
    ACT_HEATER  = 3'd0,
    ACT_COOLING = 3'd1,
    ACT_DEHUMID = 3'd2,
    ACT_SPARE   = 3'd3,
    ACT_ALL_OFF = 3'd4,
    ACT_TICK    = 3'd5,
    ACT_FAULT   = 3'd6
  } action_t;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_HEATER_LIMIT  = 3'd0,
    REG_COOLING_LIMIT = 3'd1,
    REG_SCHED_ENABLE  = 3'd2,
    REG_DAY_START     = 3'd3,
    REG_NIGHT_START   = 3'd4,
    REG_TEST_MODE     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LimitMsBits-1:0] heater_max_ms;
    logic [LimitMsBits-1:0] cooling_max_ms;
    logic                   schedule_enable;
    logic [HourBits-1:0]    day_start;
    logic [HourBits-1:0]    night_start;
    logic                   pin_hold;
  } cfg_t;

  typedef struct packed {
    logic                 heater_active;
    logic                 cooling_active;
    logic                 dehumid_active;
    logic                 spare_active;
    logic                 heater_trip;
    logic                 cooling_trip;
    logic                 sensor_fault;
    logic                 is_day;
    logic [NumRelays-1:0] pin_levels;
  } out_item_t;

endpackage

// File: sv/crsc_if.sv
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps

interface crsc_in_if;
  logic                            valid;
  logic                            ready;
  logic [crsc_pkg::ActionBits-1:0] action;
  logic                            turn_on;
  logic [crsc_pkg::HourBits-1:0]   hour_now;
  logic                            time_valid;

  modport source (output valid, action, turn_on, hour_now, time_valid, input ready);
  modport sink   (input valid, action, turn_on, hour_now, time_valid, output ready);
endinterface

interface crsc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           heater_active;
  logic                           cooling_active;
  logic                           dehumid_active;
  logic                           spare_active;
  logic                           heater_trip;
  logic                           cooling_trip;
  logic                           sensor_fault;
  logic                           is_day;
  logic [crsc_pkg::NumRelays-1:0] pin_levels;

  modport source (output valid, heater_active, cooling_active, dehumid_active, spare_active,
                  heater_trip, cooling_trip, sensor_fault, is_day, pin_levels,
                  input ready);
  modport sink   (input valid, heater_active, cooling_active, dehumid_active, spare_active,
                  heater_trip, cooling_trip, sensor_fault, is_day, pin_levels,
                  output ready);
endinterface

interface crsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [crsc_pkg::CfgIndexBits-1:0] index;
  logic [crsc_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/crsc_cfg.sv
// Configuration registers; limits are kept pre-scaled to milliseconds.
`timescale 1ns / 1ps

module crsc_cfg (
  input  logic             clk,
  input  logic             rst_n,
  crsc_cfg_if.sink         cfg_ch,
  output crsc_pkg::cfg_t   cfg
);

  crsc_pkg::cfg_t                         cfg_r;
  logic [crsc_pkg::LimitMsBits-1:0]       scaled_minutes;
  logic                                   wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  // minutes to milliseconds, one shared 16x16 product
  assign scaled_minutes = crsc_pkg::LimitMsBits'(
    {16'd0, cfg_ch.data[crsc_pkg::LimitMinutesBits-1:0]} * 32'(crsc_pkg::MsPerMinute));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heater_max_ms    <= crsc_pkg::LimitMsReset;
      cfg_r.cooling_max_ms   <= crsc_pkg::LimitMsReset;
      cfg_r.schedule_enable  <= 1'b0;
      cfg_r.day_start        <= crsc_pkg::HourBits'(crsc_pkg::DayStartReset);
      cfg_r.night_start      <= crsc_pkg::HourBits'(crsc_pkg::NightStartReset);
      cfg_r.pin_hold         <= 1'b0;
    end else if (wr) begin
      unique case (crsc_pkg::cfg_reg_t'(cfg_ch.index))
        crsc_pkg::REG_HEATER_LIMIT:  cfg_r.heater_max_ms    <= scaled_minutes;
        crsc_pkg::REG_COOLING_LIMIT: cfg_r.cooling_max_ms   <= scaled_minutes;
        crsc_pkg::REG_SCHED_ENABLE:  cfg_r.schedule_enable  <= cfg_ch.data[0];
        crsc_pkg::REG_DAY_START:     cfg_r.day_start   <= cfg_ch.data[crsc_pkg::HourBits-1:0];
        crsc_pkg::REG_NIGHT_START:   cfg_r.night_start <= cfg_ch.data[crsc_pkg::HourBits-1:0];
        crsc_pkg::REG_TEST_MODE:     cfg_r.pin_hold         <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/crsc_core.sv
// Relay state, on-time counters, safety trips and day/night decision.
`timescale 1ns / 1ps

module crsc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  crsc_in_if.sink               in_ch,
  input  logic                  can_accept,
  input  crsc_pkg::cfg_t        cfg,
  output logic                  push,
  output crsc_pkg::out_item_t   result
);

  logic                              heater_r, heater_nxt;
  logic                              cooling_r, cooling_nxt;
  logic                              dehumid_r, dehumid_nxt;
  logic                              spare_r, spare_nxt;
  logic                              heater_trip_r, heater_trip_nxt;
  logic                              cooling_trip_r, cooling_trip_nxt;
  logic                              fault_r, fault_nxt;
  logic [crsc_pkg::TimerBits-1:0]    heater_ms_r, heater_ms_nxt;
  logic [crsc_pkg::TimerBits-1:0]    cooling_ms_r, cooling_ms_nxt;
  logic [crsc_pkg::NumRelays-1:0]    pins_r, pins_nxt;
  logic [crsc_pkg::TimerBits-1:0]    heater_inc, cooling_inc;
  logic                              heater_over, cooling_over;
  logic                              is_day;
  logic                              tm;

  assign in_ch.ready = can_accept;
  assign push = in_ch.valid && can_accept;
  assign tm   = cfg.pin_hold;

  // saturating increment, then compare against the pre-scaled limit
  assign heater_inc  = (&heater_ms_r)  ? heater_ms_r  : heater_ms_r  + 1'b1;
  assign cooling_inc = (&cooling_ms_r) ? cooling_ms_r : cooling_ms_r + 1'b1;
  assign heater_over  = crsc_pkg::CmpBits'(heater_inc)  >
                        crsc_pkg::CmpBits'(cfg.heater_max_ms);
  assign cooling_over = crsc_pkg::CmpBits'(cooling_inc) >
                        crsc_pkg::CmpBits'(cfg.cooling_max_ms);

  always_comb begin
    if (!cfg.schedule_enable || !in_ch.time_valid) begin
      is_day = 1'b1;
    end else if (cfg.day_start < cfg.night_start) begin
      is_day = (in_ch.hour_now >= cfg.day_start) && (in_ch.hour_now < cfg.night_start);
    end else begin
      is_day = (in_ch.hour_now >= cfg.day_start) || (in_ch.hour_now < cfg.night_start);
    end
  end

  always_comb begin
    heater_nxt       = heater_r;
    cooling_nxt      = cooling_r;
    dehumid_nxt      = dehumid_r;
    spare_nxt        = spare_r;
    heater_trip_nxt  = heater_trip_r;
    cooling_trip_nxt = cooling_trip_r;
    fault_nxt        = fault_r;
    heater_ms_nxt    = heater_ms_r;
    cooling_ms_nxt   = cooling_ms_r;
    pins_nxt         = pins_r;
    unique case (crsc_pkg::action_t'(in_ch.action))
      crsc_pkg::ACT_HEATER: begin
        if (in_ch.turn_on) begin
          // interlock: drop cooling first
          if (cooling_r) begin
            cooling_nxt    = 1'b0;
            cooling_ms_nxt = '0;
            if (!tm) pins_nxt[crsc_pkg::PinCooling] = 1'b1;
          end
          if (!heater_r) begin
            heater_nxt      = 1'b1;
            heater_ms_nxt   = '0;
            heater_trip_nxt = 1'b0;
            if (!tm) pins_nxt[crsc_pkg::PinHeater] = 1'b0;
          end
        end else if (heater_r) begin
          heater_nxt    = 1'b0;
          heater_ms_nxt = '0;
          if (!tm) pins_nxt[crsc_pkg::PinHeater] = 1'b1;
        end
      end
      crsc_pkg::ACT_COOLING: begin
        if (in_ch.turn_on) begin
          if (heater_r) begin
            heater_nxt    = 1'b0;
            heater_ms_nxt = '0;
            if (!tm) pins_nxt[crsc_pkg::PinHeater] = 1'b1;
          end
          if (!cooling_r) begin
            cooling_nxt      = 1'b1;
            cooling_ms_nxt   = '0;
            cooling_trip_nxt = 1'b0;
            if (!tm) pins_nxt[crsc_pkg::PinCooling] = 1'b0;
          end
        end else if (cooling_r) begin
          cooling_nxt    = 1'b0;
          cooling_ms_nxt = '0;
          if (!tm) pins_nxt[crsc_pkg::PinCooling] = 1'b1;
        end
      end
      crsc_pkg::ACT_DEHUMID: begin
        if (in_ch.turn_on != dehumid_r) begin
          dehumid_nxt = in_ch.turn_on;
          if (!tm) pins_nxt[crsc_pkg::PinDehumid] = !in_ch.turn_on;
        end
      end
      crsc_pkg::ACT_SPARE: begin
        if (in_ch.turn_on != spare_r) begin
          spare_nxt = in_ch.turn_on;
          if (!tm) pins_nxt[crsc_pkg::PinSpare] = !in_ch.turn_on;
        end
      end
      crsc_pkg::ACT_ALL_OFF: begin
        if (heater_r) begin
          heater_nxt    = 1'b0;
          heater_ms_nxt = '0;
          if (!tm) pins_nxt[crsc_pkg::PinHeater] = 1'b1;
        end
        if (cooling_r) begin
          cooling_nxt    = 1'b0;
          cooling_ms_nxt = '0;
          if (!tm) pins_nxt[crsc_pkg::PinCooling] = 1'b1;
        end
        if (dehumid_r) begin
          dehumid_nxt = 1'b0;
          if (!tm) pins_nxt[crsc_pkg::PinDehumid] = 1'b1;
        end
        if (spare_r) begin
          spare_nxt = 1'b0;
          if (!tm) pins_nxt[crsc_pkg::PinSpare] = 1'b1;
        end
      end
      crsc_pkg::ACT_TICK: begin
        if (heater_r) heater_ms_nxt = heater_inc;
        if (cooling_r) cooling_ms_nxt = cooling_inc;
        if (heater_r && fault_r && heater_over) begin
          heater_nxt      = 1'b0;
          heater_ms_nxt   = '0;
          heater_trip_nxt = 1'b1;
          if (!tm) pins_nxt[crsc_pkg::PinHeater] = 1'b1;
        end
        if (cooling_r && fault_r && cooling_over) begin
          cooling_nxt      = 1'b0;
          cooling_ms_nxt   = '0;
          cooling_trip_nxt = 1'b1;
          if (!tm) pins_nxt[crsc_pkg::PinCooling] = 1'b1;
        end
      end
      crsc_pkg::ACT_FAULT: fault_nxt = in_ch.turn_on;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heater_r       <= 1'b0;
      cooling_r      <= 1'b0;
      dehumid_r      <= 1'b0;
      spare_r        <= 1'b0;
      heater_trip_r  <= 1'b0;
      cooling_trip_r <= 1'b0;
      fault_r        <= 1'b0;
      heater_ms_r    <= '0;
      cooling_ms_r   <= '0;
      pins_r         <= '1;
    end else if (push) begin
      heater_r       <= heater_nxt;
      cooling_r      <= cooling_nxt;
      dehumid_r      <= dehumid_nxt;
      spare_r        <= spare_nxt;
      heater_trip_r  <= heater_trip_nxt;
      cooling_trip_r <= cooling_trip_nxt;
      fault_r        <= fault_nxt;
      heater_ms_r    <= heater_ms_nxt;
      cooling_ms_r   <= cooling_ms_nxt;
      pins_r         <= pins_nxt;
    end
  end

  always_comb begin
    result.heater_active  = heater_nxt;
    result.cooling_active = cooling_nxt;
    result.dehumid_active = dehumid_nxt;
    result.spare_active   = spare_nxt;
    result.heater_trip    = heater_trip_nxt;
    result.cooling_trip   = cooling_trip_nxt;
    result.sensor_fault   = fault_nxt;
    result.is_day         = is_day;
    result.pin_levels     = pins_nxt;
  end

  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    !(heater_r && cooling_r))
    else $error("heater and cooling on together");

  a_trip_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(heater_trip_r) || $rose(cooling_trip_r)) |-> $past(fault_r))
    else $error("trip without sensor fault");

  a_test_mode_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(tm)) |-> $stable(pins_r))
    else $error("pin levels moved in test mode");

endmodule

// File: sv/crsc_outbuf.sv
// Result register with a skid stage behind it.
`timescale 1ns / 1ps

module crsc_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  crsc_pkg::out_item_t   push_data,
  output logic                  can_accept,
  crsc_out_if.source            out_ch
);

  crsc_pkg::out_item_t out_r, out_nxt;
  crsc_pkg::out_item_t skid_r, skid_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                skid_vld_r, skid_vld_nxt;
  logic                pop;

  assign can_accept = !skid_vld_r;
  assign pop        = out_vld_r && out_ch.ready;

  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_vld_r && !pop) begin
      // output stalled: park the new transaction in the skid stage
      if (push) begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (skid_vld_r) begin
      out_nxt      = skid_r;
      out_vld_nxt  = 1'b1;
      skid_vld_nxt = 1'b0;
    end else begin
      out_nxt     = push_data;
      out_vld_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.heater_active  = out_r.heater_active;
  assign out_ch.cooling_active = out_r.cooling_active;
  assign out_ch.dehumid_active = out_r.dehumid_active;
  assign out_ch.spare_active   = out_r.spare_active;
  assign out_ch.heater_trip    = out_r.heater_trip;
  assign out_ch.cooling_trip   = out_r.cooling_trip;
  assign out_ch.sensor_fault   = out_r.sensor_fault;
  assign out_ch.is_day         = out_r.is_day;
  assign out_ch.pin_levels     = out_r.pin_levels;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage full with empty output register");

endmodule

// File: sv/climate_relay_safety_controller.sv
// Top level: climate relay safety controller.
//
// channel | dir | handshake            | payload
// in_ch   | in  | valid/ready          | action, turn_on, hour_now, time_valid
// out_ch  | out | valid/ready          | relay states, trips, sensor_fault, is_day, pin_levels
// cfg_ch  | in  | valid/ready (always) | index, data
//
// One command per cycle while in_ch.ready is high; each result is registered.
// All state update is one compare-and-set pass; the limit scaling multiply sits on the
// configuration path, so the tick path is one increment and one 32-bit compare.
// Reset (synchronous, rst_n low) turns all relays off, clears trips, fault and counters.
// A skid stage keeps in_ch.ready high for one more transaction while out_ch is stalled.
`timescale 1ns / 1ps

module climate_relay_safety_controller (
  input  logic         clk,
  input  logic         rst_n,
  crsc_in_if.sink      in_ch,
  crsc_out_if.source   out_ch,
  crsc_cfg_if.sink     cfg_ch
);

  crsc_pkg::cfg_t      cfg;
  crsc_pkg::out_item_t result;
  logic                push;
  logic                can_accept;

  crsc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  crsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .can_accept (can_accept),
    .cfg        (cfg),
    .push       (push),
    .result     (result)
  );

  crsc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (result),
    .can_accept (can_accept),
    .out_ch     (out_ch)
  );

endmodule
